### hdl/aes128_block_mode_engine_core_defines.svh
// Assertion macros shared by the checker.
`ifndef AES128_BLOCK_MODE_ENGINE_CORE_DEFINES_SVH
`define AES128_BLOCK_MODE_ENGINE_CORE_DEFINES_SVH
// implication checked on every edge outside reset
`define AB_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("%s failed", "label");
// next-cycle implication
`define AB_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("%s failed", "label");
`endif

### hdl/ab_pkg.sv
// ----------------------------------------------------------------------------
// ab_pkg
// Shared types, codes and AES helper functions for the block mode engine.
// ----------------------------------------------------------------------------
package ab_pkg;
  localparam logic [1:0] MODE_ECB = 2'd0;
  localparam logic [1:0] MODE_CBC = 2'd1;
  localparam logic [1:0] MODE_CTR = 2'd2;

  localparam logic [2:0] REG_KEY_HI = 3'd0;
  localparam logic [2:0] REG_KEY_LO = 3'd1;
  localparam logic [2:0] REG_IV_HI  = 3'd2;
  localparam logic [2:0] REG_IV_LO  = 3'd3;
  localparam logic [2:0] REG_MODE   = 3'd4;
  localparam logic [2:0] REG_DIR    = 3'd5;

  localparam logic [4:0] BLOCK_BYTES = 5'd16;

  // operation codes for the back end
  localparam logic [2:0] OP_ECB_ENC = 3'd0;
  localparam logic [2:0] OP_ECB_DEC = 3'd1;
  localparam logic [2:0] OP_CBC_ENC = 3'd2;
  localparam logic [2:0] OP_CBC_DEC = 3'd3;
  localparam logic [2:0] OP_CTR     = 3'd4;

  // queue entry from front to back
  typedef struct packed {
    logic [2:0]   op;
    logic [127:0] data;
    logic [4:0]   vb;
    logic         first;
    logic         last;
  } job_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] inv_sbox(input logic [7:0] v);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == v) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the state, byte 0 at the top
  function automatic logic [7:0] sb(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic fin);
    logic [7:0]   t [16];
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        t[4*c+w] = SBOX[sb(s, 4*((c+w)%4)+w)];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (fin) begin
        o[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        o[127-32*c -: 32] = {xt(a0)^xt(a1)^a1^a2^a3, a0^xt(a1)^xt(a2)^a2^a3,
                             a0^a1^xt(a2)^xt(a3)^a3, xt(a0)^a0^a1^a2^xt(a3)};
      end
    end
    return o;
  endfunction

  // inverse shift rows and sub bytes
  function automatic logic [127:0] dec_sub(input logic [127:0] s);
    logic [7:0]   t [16];
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        t[4*((c+w)%4)+w] = inv_sbox(sb(s, 4*c+w));
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    return o;
  endfunction

  function automatic logic [7:0] m9(input logic [7:0] a);
    return xt(xt(xt(a))) ^ a;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3;
    logic [7:0]   e0, e1, e2, e3;
    for (int c = 0; c < 4; c++) begin
      a0 = sb(s, 4*c); a1 = sb(s, 4*c+1); a2 = sb(s, 4*c+2); a3 = sb(s, 4*c+3);
      e0 = xt(xt(a0 ^ a2)); e1 = xt(xt(a1 ^ a3));
      // 14,11,13,9 = mix columns after a 4/5 pre-step
      a0 = a0 ^ e0; a1 = a1 ^ e1; a2 = a2 ^ e0; a3 = a3 ^ e1;
      e2 = a0 ^ a1 ^ a2 ^ a3;
      e3 = e2;
      o[127-32*c -: 32] = {a0^e3^xt(a0^a1), a1^e3^xt(a1^a2),
                           a2^e3^xt(a2^a3), a3^e3^xt(a3^a0)};
    end
    return o;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = 8'h01;
      4'd1: r = 8'h02;
      4'd2: r = 8'h04;
      4'd3: r = 8'h08;
      4'd4: r = 8'h10;
      4'd5: r = 8'h20;
      4'd6: r = 8'h40;
      4'd7: r = 8'h80;
      4'd8: r = 8'h1b;
      4'd9: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [3:0] i);
    logic [31:0] w0, w1, w2, w3;
    w0 = k[127:96] ^ sub_word({k[23:0], k[31:24]}) ^ {rcon(i), 24'h0};
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction
endpackage

### hdl/ab_front.sv
// ----------------------------------------------------------------------------
// ab_front
// Classifies input words by mode and pushes jobs into a two-entry queue.
// ----------------------------------------------------------------------------
module ab_front import ab_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  mode,
  input  logic        direction,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_hi,
  input  logic [63:0] in_data_lo,
  input  logic [4:0]  in_valid_bytes,
  input  logic        in_first,
  input  logic        in_last,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);
  job_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  job_t       nj;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  always_comb begin
    nj.data  = {in_data_hi, in_data_lo};
    nj.vb    = (in_valid_bytes > BLOCK_BYTES) ? BLOCK_BYTES : in_valid_bytes;
    nj.first = in_first;
    nj.last  = in_last;
    case (mode)
      MODE_CBC: nj.op = direction ? OP_CBC_DEC : OP_CBC_ENC;
      MODE_CTR: nj.op = OP_CTR;
      default:  nj.op = direction ? OP_ECB_DEC : OP_ECB_ENC;
    endcase
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= nj;
  end
endmodule

### hdl/ab_back.sv
// ----------------------------------------------------------------------------
// ab_back
// Iterative AES-128 round engine with chaining, counter and pad handling.
// ----------------------------------------------------------------------------
module ab_back import ab_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        cfg_ready,
  input  logic [63:0] iv_hi,
  input  logic [63:0] iv_lo,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hi,
  output logic [63:0] out_lo,
  output logic [4:0]  out_bytes,
  output logic        out_last,
  output logic        pad_error
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KEXP = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [127:0] rk_mem [11];
  logic [127:0] key_r, key_nxt;
  logic [127:0] kx_r, kx_nxt;
  logic [127:0] rk_q;
  logic [3:0]   rk_addr;
  logic         rk_we;
  logic [3:0]   rk_waddr;
  logic [127:0] rk_wdata;

  logic [2:0]   st_r, st_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic [127:0] s_r, s_nxt;
  logic [127:0] chain_r, chain_nxt;
  logic [63:0]  ctr_r, ctr_nxt;
  job_t         j_r, j_nxt;
  logic         extra_r, extra_nxt;
  logic         ov_r, ov_nxt;
  logic [127:0] o_r, o_nxt;
  logic [4:0]   ob_r, ob_nxt;
  logic         ol_r, ol_nxt, oe_r, oe_nxt;
  logic         dec;
  logic [127:0] ch_cur, din, post, res;
  logic [7:0]   pad;
  logic         perr;
  logic [127:0] ctr_blk;

  // a queued word takes priority over a configuration write
  assign cfg_ready = (st_r == ST_IDLE) && !job_valid;
  assign job_ready = (st_r == ST_IDLE);
  assign out_valid = ov_r;
  assign {out_hi, out_lo} = o_r;
  assign out_bytes = ob_r;
  assign out_last  = ol_r;
  assign pad_error = oe_r;
  assign dec = (j_r.op == OP_ECB_DEC) || (j_r.op == OP_CBC_DEC);

  // round key read address: decrypt walks keys downward
  always_comb begin
    case (st_r)
      ST_IDLE: rk_addr = 4'd0;
      default: rk_addr = dec ? 4'(4'd10 - rnd_nxt) : rnd_nxt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rk_we) rk_mem[rk_waddr] <= rk_wdata;
  end

  always_ff @(posedge clk) begin
    rk_q <= rk_mem[(st_r == ST_IDLE && job_valid && job_ready &&
                   ((job.op == OP_ECB_DEC) || (job.op == OP_CBC_DEC))) ? 4'd10 : rk_addr];
  end

  always_comb begin
    st_nxt = st_r; rnd_nxt = rnd_r; s_nxt = s_r; chain_nxt = chain_r;
    ctr_nxt = ctr_r; j_nxt = j_r; extra_nxt = extra_r; ov_nxt = ov_r;
    o_nxt = o_r; ob_nxt = ob_r; ol_nxt = ol_r; oe_nxt = oe_r;
    key_nxt = key_r; kx_nxt = kx_r;
    rk_we = 1'b0; rk_waddr = rnd_r; rk_wdata = kx_r;
    din = 128'h0; post = 128'h0; res = 128'h0; pad = 8'h0; perr = 1'b0;
    ch_cur = (job.first) ? {iv_hi, iv_lo} : chain_r;
    ctr_blk = 128'h0;
    for (int i = 0; i < 8; i++) ctr_blk[63-8*i -: 8] = ctr_r[8*i +: 8];

    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (st_r)
      ST_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          case (cfg_index)
            REG_KEY_HI: begin
              key_nxt = {cfg_data, key_r[63:0]};
              st_nxt = ST_KEXP; rnd_nxt = 4'd0; kx_nxt = key_nxt;
            end
            REG_KEY_LO: begin
              key_nxt = {key_r[127:64], cfg_data};
              st_nxt = ST_KEXP; rnd_nxt = 4'd0; kx_nxt = key_nxt;
            end
            default: ;
          endcase
        end else if (job_valid) begin
          j_nxt = job;
          rnd_nxt = 4'd0;
          extra_nxt = 1'b0;
          if (job.first) begin
            chain_nxt = {iv_hi, iv_lo};
          end
          din = job.data;
          case (job.op)
            OP_CBC_ENC: begin
              if (job.last && job.vb < BLOCK_BYTES) begin
                for (int i = 0; i < 16; i++)
                  if (5'(i) >= job.vb) din[127-8*i -: 8] = 8'(BLOCK_BYTES - job.vb);
              end
              extra_nxt = job.last && (job.vb == BLOCK_BYTES);
              din = din ^ ch_cur;
            end
            OP_CTR: begin
              din = {iv_hi, ctr_blk[63:0]};
              if (job.first) din = {iv_hi, 64'h0};
            end
            default: ;
          endcase
          s_nxt = din;
          st_nxt = ST_RUN;
        end
      end
      ST_KEXP: begin
        rk_we = 1'b1;
        rk_waddr = rnd_r;
        rk_wdata = kx_r;
        kx_nxt = next_key(kx_r, rnd_r);
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == 4'd10) st_nxt = ST_IDLE;
      end
      ST_RUN: begin
        // rk_q holds the key for step rnd_r
        if (rnd_r == 4'd0) begin
          s_nxt = s_r ^ rk_q;
        end else if (dec) begin
          post = dec_sub(s_r) ^ rk_q;
          s_nxt = (rnd_r == 4'd10) ? post : inv_mix(post);
        end else begin
          s_nxt = enc_round(s_r, rnd_r == 4'd10) ^ rk_q;
        end
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == 4'd10) st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!ov_r || out_ready) begin
          ob_nxt = BLOCK_BYTES; ol_nxt = j_r.last; oe_nxt = 1'b0;
          res = s_r;
          case (j_r.op)
            OP_CBC_ENC: begin
              chain_nxt = s_r;
              if (extra_r) ol_nxt = 1'b0;
            end
            OP_CBC_DEC: begin
              res = s_r ^ chain_r;
              chain_nxt = j_r.data;
              if (j_r.last) begin
                pad = res[7:0];
                if (pad == 8'h0 || pad > 8'h10) perr = 1'b1;
                for (int i = 0; i < 16; i++)
                  if (8'(i) >= 8'(8'h10 - pad) && res[127-8*i -: 8] != pad) perr = 1'b1;
                if (!perr) begin
                  for (int i = 0; i < 16; i++)
                    if (8'(i) >= 8'(8'h10 - pad)) res[127-8*i -: 8] = 8'h0;
                  ob_nxt = 5'(8'h10 - pad);
                end
                oe_nxt = perr;
              end
            end
            OP_CTR: begin
              res = j_r.data ^ s_r;
              for (int i = 0; i < 16; i++)
                if (5'(i) >= j_r.vb) res[127-8*i -: 8] = 8'h0;
              ob_nxt = j_r.vb;
              ctr_nxt = (j_r.first ? 64'h0 : ctr_r) + 64'd1;
            end
            default: ;
          endcase
          if (j_r.first && j_r.op != OP_CBC_ENC && j_r.op != OP_CBC_DEC)
            chain_nxt = {iv_hi, iv_lo};
          if (j_r.first && j_r.op != OP_CTR) ctr_nxt = 64'h0;
          o_nxt = res;
          ov_nxt = 1'b1;
          if (extra_r) begin
            // padding block of sixteen 0x10 bytes
            extra_nxt = 1'b0;
            j_nxt.last = 1'b1;
            j_nxt.first = 1'b0;
            s_nxt = {16{8'h10}} ^ s_r;
            rnd_nxt = 4'd0;
            st_nxt = ST_OUT;
          end else begin
            st_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        // a spare state for the key 0 read before the padding block rounds
        rnd_nxt = 4'd0;
        st_nxt = ST_RUN;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; rnd_r <= 4'd0; ov_r <= 1'b0; extra_r <= 1'b0;
      chain_r <= 128'h0; ctr_r <= 64'h0; key_r <= 128'h0;
    end else begin
      st_r <= st_nxt; rnd_r <= rnd_nxt; ov_r <= ov_nxt; extra_r <= extra_nxt;
      chain_r <= chain_nxt; ctr_r <= ctr_nxt; key_r <= key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt; j_r <= j_nxt; o_r <= o_nxt; ob_r <= ob_nxt;
    ol_r <= ol_nxt; oe_r <= oe_nxt; kx_r <= kx_nxt;
  end
endmodule

### hdl/aes128_block_mode_engine_core.sv
// ----------------------------------------------------------------------------
// aes128_block_mode_engine_core
// AES-128 engine for ECB, CBC with PKCS#7 padding and CTR, one block a word.
// ----------------------------------------------------------------------------
// A block goes from queue to result register through one key read, eleven
// round steps over the stored round keys and one finishing step; a full last
// CBC encrypt block yields a second word, a padding block run through again.
// The single shared round unit takes one block at a time. A two-word queue in
// front lets input words be taken while the engine runs. Writing key_hi or
// key_lo expands the key into the round key store; write a key before data.
// Configuration is taken only while the engine is idle with an empty queue.
module aes128_block_mode_engine_core import ab_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_hi,
  input  logic [63:0] in_data_lo,
  input  logic [4:0]  in_valid_bytes,
  input  logic        in_first,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hi,
  output logic [63:0] out_lo,
  output logic [4:0]  out_bytes,
  output logic        out_last,
  output logic        pad_error
);
  logic [63:0] iv_hi_r, iv_lo_r;
  logic [1:0]  mode_r;
  logic        dir_r;
  logic        job_valid, job_ready;
  job_t        job;
  logic        wr;

  assign wr = cfg_valid && cfg_ready;

  // plain registers; key words live in the back end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_hi_r <= 64'h0; iv_lo_r <= 64'h0; mode_r <= MODE_ECB; dir_r <= 1'b0;
    end else if (wr) begin
      case (cfg_index)
        REG_IV_HI: iv_hi_r <= cfg_data;
        REG_IV_LO: iv_lo_r <= cfg_data;
        REG_MODE:  mode_r  <= cfg_data[1:0];
        REG_DIR:   dir_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ab_front u_front (
    .clk, .rst_n, .mode(mode_r), .direction(dir_r),
    .in_valid, .in_ready, .in_data_hi, .in_data_lo, .in_valid_bytes,
    .in_first, .in_last, .job_valid, .job_ready, .job
  );

  ab_back u_back (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data, .cfg_ready,
    .iv_hi(iv_hi_r), .iv_lo(iv_lo_r), .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .out_hi, .out_lo, .out_bytes, .out_last, .pad_error
  );
endmodule

### hdl/ab_checker.sv
// ----------------------------------------------------------------------------
// ab_checker
// Port-level checks on the engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "aes128_block_mode_engine_core_defines.svh"
module ab_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_ready,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_bytes,
  input logic       pad_error
);
  `AB_ASSERT_IMP(a_bytes_range, clk, rst_n, out_valid, out_bytes <= 5'd16)
  `AB_ASSERT_NXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)
  `AB_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_bytes) && $stable(pad_error))
  `AB_ASSERT_IMP(a_err_full, clk, rst_n, out_valid && pad_error, out_bytes == 5'd16)
  `AB_ASSERT_IMP(a_cfg_idle, clk, rst_n, cfg_ready, in_ready)
endmodule

bind aes128_block_mode_engine_core ab_checker u_ab_checker (
  .clk, .rst_n, .cfg_ready, .in_ready, .out_valid, .out_ready, .out_bytes, .pad_error
);

### tb/sv/aes128_block_mode_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_mode_engine_core_tb
// Self-checking bench for the AES-128 ECB / CBC-PKCS#7 / CTR block engine.
// ----------------------------------------------------------------------------
// A directed table is walked first. It covers field extremes, every mode and
// direction, padding corners, CTR partial blocks and the reserved mode.
// Random messages follow under several key, IV and mode settings. Every
// accepted word is run through a local AES model. Results are checked in order
// against the queue of predicted words.
// ----------------------------------------------------------------------------
module aes128_block_mode_engine_core_tb;
  import ab_pkg::*;

  localparam logic [1:0] MODE_RSVD = 2'd3;
  localparam logic       DIR_ENC   = 1'b0;
  localparam logic       DIR_DEC   = 1'b1;
  localparam int         STALL_LIMIT   = 20000;
  localparam int         DRAIN_CYCLES  = 40;
  localparam int         HOLD_CYCLES   = 700;
  localparam int         PHASE_WORDS   = 140;
  localparam int         NUM_PHASES    = 14;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_data_hi = '0;
  logic [63:0] in_data_lo = '0;
  logic [4:0]  in_valid_bytes = '0;
  logic        in_first = 1'b0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_hi;
  logic [63:0] out_lo;
  logic [4:0]  out_bytes;
  logic        out_last;
  logic        pad_error;

  aes128_block_mode_engine_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one predicted output word
  typedef struct {
    logic [127:0] blk;
    logic [4:0]   nbytes;
    logic         lastf;
    logic         err;
  } cipher_word_t;

  cipher_word_t cipher_words_due[$];

  // local copy of the engine's registers and chaining state
  logic [63:0]  key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic [1:0]   mode_r;
  logic         dir_r;
  logic [127:0] rkeys [11];
  logic [127:0] chain_r;
  logic [63:0]  ctr_r;
  logic [7:0]   inv_box [256];

  int mismatches = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  initial begin
    for (int i = 0; i < 256; i++) inv_box[SBOX[i]] = 8'(i);
  end

  // ---------------------------------------------------------------- AES model
  function automatic logic [7:0] gf2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gfmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf2(a);
    end
    return p;
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    w[0] = key_hi_r[63:32]; w[1] = key_hi_r[31:0];
    w[2] = key_lo_r[63:32]; w[3] = key_lo_r[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]} ^ {rc, 24'h0};
        rc = gf2(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rkeys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] pt);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [127:0] v;
    v = pt ^ rkeys[0];
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) s[i] = v[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) t[4*c+w] = SBOX[s[4*((c+w)%4)+w]];
      for (int c = 0; c < 4; c++) begin
        if (r < 10) begin
          s[4*c]   = gf2(t[4*c]) ^ gf2(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
          s[4*c+1] = t[4*c] ^ gf2(t[4*c+1]) ^ gf2(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
          s[4*c+2] = t[4*c] ^ t[4*c+1] ^ gf2(t[4*c+2]) ^ gf2(t[4*c+3]) ^ t[4*c+3];
          s[4*c+3] = gf2(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ gf2(t[4*c+3]);
        end else begin
          for (int w = 0; w < 4; w++) s[4*c+w] = t[4*c+w];
        end
      end
      for (int i = 0; i < 16; i++) v[127-8*i -: 8] = s[i];
      v ^= rkeys[r];
    end
    return v;
  endfunction

  function automatic logic [127:0] aes_decrypt(input logic [127:0] ct);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [127:0] v;
    v = ct ^ rkeys[10];
    for (int r = 9; r >= 0; r--) begin
      for (int i = 0; i < 16; i++) s[i] = v[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) t[4*((c+w)%4)+w] = inv_box[s[4*c+w]];
      for (int i = 0; i < 16; i++) v[127-8*i -: 8] = t[i];
      v ^= rkeys[r];
      if (r > 0) begin
        for (int i = 0; i < 16; i++) t[i] = v[127-8*i -: 8];
        for (int c = 0; c < 4; c++) begin
          s[4*c]   = gfmul(t[4*c], 8'd14) ^ gfmul(t[4*c+1], 8'd11) ^ gfmul(t[4*c+2], 8'd13)
                   ^ gfmul(t[4*c+3], 8'd9);
          s[4*c+1] = gfmul(t[4*c], 8'd9) ^ gfmul(t[4*c+1], 8'd14) ^ gfmul(t[4*c+2], 8'd11)
                   ^ gfmul(t[4*c+3], 8'd13);
          s[4*c+2] = gfmul(t[4*c], 8'd13) ^ gfmul(t[4*c+1], 8'd9) ^ gfmul(t[4*c+2], 8'd14)
                   ^ gfmul(t[4*c+3], 8'd11);
          s[4*c+3] = gfmul(t[4*c], 8'd11) ^ gfmul(t[4*c+1], 8'd13) ^ gfmul(t[4*c+2], 8'd9)
                   ^ gfmul(t[4*c+3], 8'd14);
        end
        for (int i = 0; i < 16; i++) v[127-8*i -: 8] = s[i];
      end
    end
    return v;
  endfunction

  function automatic void push_word(logic [127:0] b, logic [4:0] n, logic l, logic e);
    cipher_word_t cw;
    cw.blk = b; cw.nbytes = n; cw.lastf = l; cw.err = e;
    cipher_words_due.push_back(cw);
  endfunction

  // works out the output word(s) for one accepted input word
  function automatic void predict_block(logic [127:0] data, logic [4:0] vb_in,
                                        logic first, logic last);
    logic [127:0] b, ks;
    logic [4:0]   vb;
    logic [7:0]   pad;
    logic         err;
    vb = (vb_in > BLOCK_BYTES) ? BLOCK_BYTES : vb_in;
    if (first) begin
      chain_r = {iv_hi_r, iv_lo_r};
      ctr_r   = '0;
    end
    b = data;
    if (mode_r == MODE_CBC && dir_r == DIR_ENC) begin
      if (last && vb < BLOCK_BYTES)
        for (int i = 0; i < 16; i++) if (i >= vb) b[127-8*i -: 8] = 8'(16 - vb);
      chain_r = aes_encrypt(b ^ chain_r);
      push_word(chain_r, BLOCK_BYTES, last && vb < BLOCK_BYTES, 1'b0);
      if (last && vb == BLOCK_BYTES) begin
        // whole last block: a full block of pad follows
        chain_r = aes_encrypt({16{8'h10}} ^ chain_r);
        push_word(chain_r, BLOCK_BYTES, 1'b1, 1'b0);
      end
    end else if (mode_r == MODE_CBC) begin
      b = aes_decrypt(data) ^ chain_r;
      chain_r = data;
      err = 1'b0;
      vb = BLOCK_BYTES;
      if (last) begin
        pad = b[7:0];
        if (pad == 0 || pad > 16) err = 1'b1;
        else for (int i = 16 - pad; i < 16; i++) if (b[127-8*i -: 8] != pad) err = 1'b1;
        if (!err) begin
          for (int i = 16 - pad; i < 16; i++) b[127-8*i -: 8] = 8'h00;
          vb = 5'(16 - pad);
        end
      end
      push_word(b, vb, last, err);
    end else if (mode_r == MODE_CTR) begin
      // counter goes in little-endian
      ks = aes_encrypt({iv_hi_r, {<<8{ctr_r}}});
      ctr_r++;
      b = data ^ ks;
      for (int i = 0; i < 16; i++) if (i >= vb) b[127-8*i -: 8] = 8'h00;
      push_word(b, vb, last, 1'b0);
    end else begin
      // ECB, reserved mode included
      push_word(dir_r ? aes_decrypt(data) : aes_encrypt(data), BLOCK_BYTES, last, 1'b0);
    end
  endfunction

  // ------------------------------------------------------------------ drivers
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KEY_HI: begin key_hi_r = val; expand_round_keys(); end
      REG_KEY_LO: begin key_lo_r = val; expand_round_keys(); end
      REG_IV_HI:  iv_hi_r = val;
      REG_IV_LO:  iv_lo_r = val;
      REG_MODE:   mode_r = val[1:0];
      REG_DIR:    dir_r = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_word(input logic [127:0] data, input logic [4:0] vb,
                           input logic first, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_data_hi     <= data[127:64];
    in_data_lo     <= data[63:0];
    in_valid_bytes <= vb;
    in_first       <= first;
    in_last        <= last;
    do @(posedge clk); while (!in_ready);
    predict_block(data, vb, first, last);
    burst_left--;
    @(negedge clk);
  endtask

  // waits out every predicted word, then the engine's own tail
  task automatic drain_engine();
    in_valid <= 1'b0;
    while (cipher_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m, input logic d);
    write_reg(REG_MODE, {62'h0, m});
    write_reg(REG_DIR, {63'h0, d});
  endtask

  // ----------------------------------------------------------------- receiver
  int rx_pattern = 0;
  int rx_left = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      hold_req  <= 1'b0;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_pattern <= $urandom_range(0, 3);
        rx_left    <= $urandom_range(50, 300);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_pattern)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // --------------------------------------------------------- checker, watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    cipher_word_t cw;
    if (rst_n && out_valid && out_ready) begin
      if (cipher_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: hi=%h lo=%h bytes=%0d last=%b err=%b",
                   out_hi, out_lo, out_bytes, out_last, pad_error);
      end else begin
        cw = cipher_words_due.pop_front();
        if ({out_hi, out_lo} !== cw.blk || out_bytes !== cw.nbytes ||
            out_last !== cw.lastf || pad_error !== cw.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%0d/%b/%b got %h%h/%0d/%b/%b",
                     cw.blk, cw.nbytes, cw.lastf, cw.err,
                     out_hi, out_lo, out_bytes, out_last, pad_error);
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("aes128_block_mode_engine_core_tb: FAIL");
      $finish;
    end
  end

  // ----------------------------------------------------------- directed table
  typedef struct {
    logic [1:0]   mode;
    logic         dir;
    logic [127:0] data;
    logic [4:0]   vb;
    logic         first;
    logic         last;
    bit           typed;     // expected word written in below
    logic [127:0] exp_blk;
    logic [4:0]   exp_bytes;
  } directed_row_t;

  localparam logic [127:0] ONES = {128{1'b1}};
  localparam logic [127:0] RAMP = 128'h00112233445566778899aabbccddeeff;

  directed_row_t rows [17] = '{
    // zero key, zero block: the well-known AES-128 answer
    '{MODE_ECB, DIR_ENC, '0, 5'd16, 1'b1, 1'b1, 1'b1,
      128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 5'd16},
    '{MODE_ECB, DIR_ENC, ONES, 5'd0, 1'b0, 1'b0, 1'b0, '0, '0},
    '{MODE_ECB, DIR_DEC, '0, 5'd31, 1'b1, 1'b0, 1'b0, '0, '0},
    '{MODE_ECB, DIR_DEC, ONES, 5'd16, 1'b0, 1'b1, 1'b0, '0, '0},
    '{MODE_RSVD, DIR_ENC, RAMP, 5'd3, 1'b1, 1'b1, 1'b0, '0, '0},
    '{MODE_RSVD, DIR_DEC, RAMP, 5'd16, 1'b0, 1'b0, 1'b0, '0, '0},
    // CBC encrypt: short last, empty last, whole last with the extra block
    '{MODE_CBC, DIR_ENC, RAMP, 5'd16, 1'b1, 1'b0, 1'b0, '0, '0},
    '{MODE_CBC, DIR_ENC, ONES, 5'd5, 1'b0, 1'b1, 1'b0, '0, '0},
    '{MODE_CBC, DIR_ENC, ONES, 5'd0, 1'b1, 1'b1, 1'b0, '0, '0},
    '{MODE_CBC, DIR_ENC, '0, 5'd16, 1'b1, 1'b1, 1'b0, '0, '0},
    '{MODE_CBC, DIR_ENC, ONES, 5'd31, 1'b0, 1'b1, 1'b0, '0, '0},
    '{MODE_CBC, DIR_DEC, ONES, 5'd16, 1'b1, 1'b0, 1'b0, '0, '0},
    '{MODE_CBC, DIR_DEC, '0, 5'd7, 1'b0, 1'b1, 1'b0, '0, '0},
    // CTR: zero length last word comes back empty
    '{MODE_CTR, DIR_ENC, RAMP, 5'd16, 1'b1, 1'b0, 1'b0, '0, '0},
    '{MODE_CTR, DIR_ENC, ONES, 5'd0, 1'b0, 1'b1, 1'b1, '0, 5'd0},
    '{MODE_CTR, DIR_ENC, ONES, 5'd31, 1'b1, 1'b1, 1'b0, '0, '0},
    '{MODE_CTR, DIR_DEC, RAMP, 5'd9, 1'b0, 1'b1, 1'b0, '0, '0}
  };

  // ------------------------------------------------------- random messages
  task automatic random_message(inout int sent);
    logic [127:0] plain [8];
    logic [127:0] ct, chain;
    logic [4:0]   vb;
    int           nblk, padn;
    bit           noisy;
    nblk  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
    noisy = ($urandom_range(0, 9) == 0);
    vb    = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(17, 31))
                                        : 5'($urandom_range(0, 16));
    for (int i = 0; i < nblk; i++)
      plain[i] = {$urandom, $urandom, $urandom, $urandom};
    if (mode_r == MODE_CBC && dir_r == DIR_DEC && !noisy) begin
      // build a properly padded ciphertext, now and then with a broken pad
      padn = $urandom_range(1, 16);
      for (int i = 16 - padn; i < 16; i++) plain[nblk-1][127-8*i -: 8] = 8'(padn);
      chain = {iv_hi_r, iv_lo_r};
      for (int i = 0; i < nblk; i++) begin
        chain = aes_encrypt(plain[i] ^ chain);
        plain[i] = chain;
      end
      if ($urandom_range(0, 4) == 0) plain[nblk-1][7'($urandom_range(0, 127))] ^= 1'b1;
    end
    for (int i = 0; i < nblk; i++) begin
      if (noisy)
        send_word(plain[i], 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      else
        send_word(plain[i], (i == nblk - 1) ? vb : BLOCK_BYTES, i == 0, i == nblk - 1);
      sent++;
    end
  endtask

  // ------------------------------------------------------------------- main
  initial begin
    logic [1:0] pm;
    logic       pd;
    int         sent;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_reg(REG_KEY_HI, 64'h0);
    write_reg(REG_KEY_LO, 64'h0);
    write_reg(REG_IV_HI, 64'h0f1e2d3c4b5a6978);
    write_reg(REG_IV_LO, 64'h8796a5b4c3d2e1f0);
    set_mode(MODE_ECB, DIR_ENC);

    foreach (rows[i]) begin
      if (rows[i].mode != mode_r || rows[i].dir != dir_r) begin
        drain_engine();
        set_mode(rows[i].mode, rows[i].dir);
      end
      send_word(rows[i].data, rows[i].vb, rows[i].first, rows[i].last);
      if (rows[i].typed) begin
        cipher_words_due[$].blk    = rows[i].exp_blk;
        cipher_words_due[$].nbytes = rows[i].exp_bytes;
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_engine();
      case (p % 7)
        0: begin pm = MODE_ECB;  pd = DIR_ENC; end
        1: begin pm = MODE_ECB;  pd = DIR_DEC; end
        2: begin pm = MODE_CBC;  pd = DIR_ENC; end
        3: begin pm = MODE_CBC;  pd = DIR_DEC; end
        4: begin pm = MODE_CTR;  pd = DIR_ENC; end
        5: begin pm = MODE_CTR;  pd = DIR_DEC; end
        default: begin pm = MODE_RSVD; pd = 1'($urandom_range(0, 1)); end
      endcase
      // key and IV extremes on the early phases, random after that
      write_reg(REG_KEY_HI, (p == 1) ? '1 : (p == 2) ? '0 : {$urandom, $urandom});
      write_reg(REG_KEY_LO, (p == 1) ? '1 : (p == 2) ? '0 : {$urandom, $urandom});
      write_reg(REG_IV_HI, (p == 3) ? '1 : (p == 4) ? '0 : {$urandom, $urandom});
      write_reg(REG_IV_LO, (p == 3) ? '1 : (p == 4) ? '0 : {$urandom, $urandom});
      set_mode(pm, pd);
      if (p == 2) hold_req = 1'b1;   // long back-pressure while words keep coming
      sent = 0;
      while (sent < PHASE_WORDS) random_message(sent);
    end

    drain_engine();
    if (mismatches == 0 && cipher_words_due.size() == 0)
      $display("aes128_block_mode_engine_core_tb: PASS");
    else
      $display("aes128_block_mode_engine_core_tb: FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/ab_pkg.sv
hdl/ab_front.sv
hdl/ab_back.sv
hdl/aes128_block_mode_engine_core.sv
hdl/ab_checker.sv
tb/sv/aes128_block_mode_engine_core_tb.sv
